// File: rtl/xdes_pkg.sv
// ----------------------------------------------------------------------------
// xdes_pkg
// Shared types and constants for the XML declaration encoding scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package xdes_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int UNIT_BITS       = 21;
  localparam int QUEUE_DEPTH_DEF = 2;

  // pseudo-attribute name searched for
  localparam int                  TARGET_LEN  = 8;
  localparam logic [0:7][7:0]     TARGET_NAME = "encoding";
  localparam int                  NAME_IDX_BITS = $clog2(TARGET_LEN);
  localparam logic [3:0]          NAME_LEN_MAX  = 4'd15;

  localparam logic [UNIT_BITS-1:0] CH_SPACE  = 21'h20;
  localparam logic [UNIT_BITS-1:0] CH_TAB    = 21'h09;
  localparam logic [UNIT_BITS-1:0] CH_CR     = 21'h0D;
  localparam logic [UNIT_BITS-1:0] CH_LF     = 21'h0A;
  localparam logic [UNIT_BITS-1:0] CH_QMARK  = 21'h3F;
  localparam logic [UNIT_BITS-1:0] CH_GT     = 21'h3E;
  localparam logic [UNIT_BITS-1:0] CH_EQ     = 21'h3D;
  localparam logic [UNIT_BITS-1:0] CH_DQUOTE = 21'h22;
  localparam logic [UNIT_BITS-1:0] CH_SQUOTE = 21'h27;
  localparam logic [UNIT_BITS-1:0] CH_UC_A   = 21'h41;
  localparam logic [UNIT_BITS-1:0] CH_UC_Z   = 21'h5A;
  localparam logic [UNIT_BITS-1:0] CH_LC_A   = 21'h61;
  localparam logic [UNIT_BITS-1:0] CH_LC_Z   = 21'h7A;

  typedef enum logic [2:0] {
    ST_MORE   = 3'd0,
    ST_END    = 3'd1,
    ST_FOUND  = 3'd2,
    ST_EMPTYN = 3'd3,
    ST_NOEQ   = 3'd4,
    ST_NOQ    = 3'd5,
    ST_EMPTYV = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    PH_WS_NAME,
    PH_QMARK,
    PH_NAME,
    PH_WS_EQ,
    PH_WS_QUOTE,
    PH_VAL_FIRST,
    PH_VAL
  } phase_t;

  // classified code unit, as carried from front to back
  typedef struct packed {
    logic                  ws;
    logic                  qmark;
    logic                  gt;
    logic                  eq;
    logic                  dquote;
    logic                  squote;
    logic                  letter;
    logic [TARGET_LEN-1:0] name_hit;
    logic                  last;
  } unit_class_t;

endpackage

`default_nettype wire

// File: rtl/xdes_front.sv
// ----------------------------------------------------------------------------
// xdes_front
// Input side: accepts code units and reduces each to a small class record.
// ----------------------------------------------------------------------------
`default_nettype none

module xdes_front import xdes_pkg::*; (
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [UNIT_BITS-1:0] code_unit,
  input  wire logic                 last_unit,
  input  wire logic                 q_full,
  output logic                      q_push,
  output unit_class_t               q_wdata
);

  always_comb begin
    q_wdata        = '0;
    q_wdata.ws     = (code_unit == CH_SPACE) || (code_unit == CH_TAB) ||
                     (code_unit == CH_CR) || (code_unit == CH_LF);
    q_wdata.qmark  = (code_unit == CH_QMARK);
    q_wdata.gt     = (code_unit == CH_GT);
    q_wdata.eq     = (code_unit == CH_EQ);
    q_wdata.dquote = (code_unit == CH_DQUOTE);
    q_wdata.squote = (code_unit == CH_SQUOTE);
    q_wdata.letter = ((code_unit >= CH_LC_A) && (code_unit <= CH_LC_Z)) ||
                     ((code_unit >= CH_UC_A) && (code_unit <= CH_UC_Z));
    for (int i = 0; i < TARGET_LEN; i++) begin
      q_wdata.name_hit[i] = (code_unit == {{(UNIT_BITS-8){1'b0}}, TARGET_NAME[i]});
    end
    q_wdata.last   = last_unit;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

endmodule

`default_nettype wire

// File: rtl/xdes_queue.sv
// ----------------------------------------------------------------------------
// xdes_queue
// Short FIFO of classified units between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module xdes_queue import xdes_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire unit_class_t wdata,
  input  wire logic        pop,
  output unit_class_t      rdata,
  output logic             not_empty,
  output logic             full
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  unit_class_t         entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_FULL);
  assign rdata     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/xdes_back.sv
// ----------------------------------------------------------------------------
// xdes_back
// Scan state machine over classified units, with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module xdes_back import xdes_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire unit_class_t            q_rdata,
  input  wire logic                   q_not_empty,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2:0]                  status,
  output logic [OFFSET_BITS-1:0]      value_start,
  output logic [OFFSET_BITS-1:0]      value_end
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  phase_t                   phase, phase_next;
  logic [OFFSET_BITS-1:0]   position, position_next;
  logic [3:0]               name_length, name_length_next;
  logic                     name_matches, name_matches_next;
  logic                     quote_is_single, quote_is_single_next;
  logic [OFFSET_BITS-1:0]   start_offset, start_offset_next;
  logic                     decided, decided_next;

  logic                     res_valid;
  status_t                  res_status;
  logic [OFFSET_BITS-1:0]   res_start;
  logic [OFFSET_BITS-1:0]   res_end;
  logic                     close_hit;
  logic [3:0]               len_inc;

  assign q_pop     = q_not_empty && (!out_valid || out_ready);
  assign close_hit = quote_is_single ? q_rdata.squote : q_rdata.dquote;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WS_NAME;
      position        <= '0;
      name_length     <= '0;
      name_matches    <= 1'b1;
      quote_is_single <= 1'b0;
      start_offset    <= '0;
      decided         <= 1'b0;
    end else if (q_pop) begin
      phase           <= phase_next;
      position        <= position_next;
      name_length     <= name_length_next;
      name_matches    <= name_matches_next;
      quote_is_single <= quote_is_single_next;
      start_offset    <= start_offset_next;
      decided         <= decided_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    name_length_next     = name_length;
    name_matches_next    = name_matches;
    quote_is_single_next = quote_is_single;
    start_offset_next    = start_offset;
    decided_next         = decided;
    res_valid            = 1'b0;
    res_status           = ST_MORE;
    res_start            = '0;
    res_end              = '0;
    len_inc              = (name_length < NAME_LEN_MAX) ? name_length + 1'b1 : name_length;

    if (!decided) begin
      unique case (phase)
        PH_WS_NAME: begin
          if (q_rdata.ws) begin
          end else if (q_rdata.qmark) begin
            if (q_rdata.last) begin
              res_valid  = 1'b1;
              res_status = ST_EMPTYN;
            end else begin
              phase_next = PH_QMARK;
            end
          end else if (q_rdata.letter) begin
            // first letter of a new name
            name_length_next  = 4'd1;
            name_matches_next = q_rdata.name_hit[0];
            phase_next        = PH_NAME;
          end else begin
            res_valid  = 1'b1;
            res_status = ST_EMPTYN;
          end
        end
        PH_QMARK: begin
          res_valid  = 1'b1;
          res_status = q_rdata.gt ? ST_END : ST_EMPTYN;
        end
        PH_NAME: begin
          if (q_rdata.letter) begin
            if ((name_length >= 4'(TARGET_LEN)) ||
                !q_rdata.name_hit[name_length[NAME_IDX_BITS-1:0]]) begin
              name_matches_next = 1'b0;
            end
            name_length_next = len_inc;
          end else if (q_rdata.ws) begin
            phase_next = PH_WS_EQ;
          end else if (q_rdata.eq) begin
            phase_next = PH_WS_QUOTE;
          end else begin
            res_valid  = 1'b1;
            res_status = ST_NOEQ;
          end
        end
        PH_WS_EQ: begin
          if (q_rdata.ws) begin
          end else if (q_rdata.eq) begin
            phase_next = PH_WS_QUOTE;
          end else begin
            res_valid  = 1'b1;
            res_status = ST_NOEQ;
          end
        end
        PH_WS_QUOTE: begin
          if (q_rdata.ws) begin
          end else if (q_rdata.dquote || q_rdata.squote) begin
            quote_is_single_next = q_rdata.squote;
            start_offset_next    = (position < POS_MAX) ? position + 1'b1 : POS_MAX;
            phase_next           = PH_VAL_FIRST;
          end else begin
            res_valid  = 1'b1;
            res_status = ST_NOQ;
          end
        end
        PH_VAL_FIRST: begin
          if (close_hit) begin
            res_valid  = 1'b1;
            res_status = ST_EMPTYV;
          end else begin
            phase_next = PH_VAL;
          end
        end
        PH_VAL: begin
          if (close_hit) begin
            if ((name_length == 4'(TARGET_LEN)) && name_matches) begin
              res_valid  = 1'b1;
              res_status = ST_FOUND;
              res_start  = start_offset;
              res_end    = position;
            end else begin
              phase_next = PH_WS_NAME;
            end
          end
        end
        default: begin
          phase_next = PH_WS_NAME;
        end
      endcase
      if (!res_valid && q_rdata.last) begin
        res_valid  = 1'b1;
        res_status = ST_MORE;
      end
    end

    position_next = (position < POS_MAX) ? position + 1'b1 : POS_MAX;
    if (res_valid) begin
      decided_next = 1'b1;
    end

    // end of buffer: restart the scan
    if (q_rdata.last) begin
      phase_next           = PH_WS_NAME;
      position_next        = '0;
      name_length_next     = '0;
      name_matches_next    = 1'b1;
      quote_is_single_next = 1'b0;
      start_offset_next    = '0;
      decided_next         = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      status      <= res_status;
      value_start <= res_start;
      value_end   <= res_end;
    end
  end

endmodule

`default_nettype wire

// File: rtl/xml_decl_encoding_scanner.sv
// ----------------------------------------------------------------------------
// xml_decl_encoding_scanner
// Finds the encoding pseudo-attribute in the text after an XML declaration.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one code unit per transaction, with
// last_unit set on the final unit of a buffer. Output channel
// (out_valid/out_ready): exactly one status per buffer, carried on the
// unit that decides it, or on the last unit as need-more. When the status
// is found, value_start and value_end give the offsets of the first value
// character and of the closing quote; otherwise both are zero.
// Throughput: one unit per cycle while no result is stalled. A front stage
// classifies each unit into a two-entry queue; the back state machine takes
// one entry per cycle while no result is stalled, and loads the result
// register. Each unit passes through its queue entry, and the result it
// decides is registered before it shows on out_valid.
// When out_ready is low with a result waiting, the back holds; the queue
// then fills and in_ready drops once it holds two units.
// Reset clears the queue, out_valid and the scan state; the block is
// ready for units as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module xml_decl_encoding_scanner import xdes_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [UNIT_BITS-1:0]   code_unit,
  input  wire logic                   last_unit,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2:0]                  status,
  output logic [OFFSET_BITS-1:0]      value_start,
  output logic [OFFSET_BITS-1:0]      value_end
);

  unit_class_t q_wdata;
  unit_class_t q_rdata;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;

  xdes_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  xdes_queue #(
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  xdes_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_rdata     (q_rdata),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .value_start (value_start),
    .value_end   (value_end)
  );

endmodule

`default_nettype wire

// File: rtl/xdes_checker.sv
// ----------------------------------------------------------------------------
// xdes_checker
// Port-level checks on the scanner's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xdes_checker import xdes_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [2:0]             status,
  input wire logic [OFFSET_BITS-1:0] value_start,
  input wire logic [OFFSET_BITS-1:0] value_end
);

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(value_start) && $stable(value_end))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 3'd7))
    else $error("undefined status code");

  a_offsets_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_FOUND) |-> (value_start == '0) && (value_end == '0))
    else $error("offsets set on a status other than found");

  a_offsets_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FOUND) |-> (value_start <= value_end))
    else $error("value start past value end");

endmodule

bind xml_decl_encoding_scanner xdes_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_xdes_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .value_start (value_start),
  .value_end   (value_end)
);

`default_nettype wire
